### hw/rtl/max_pairwise_bitset_overlap_unit_defines.svh
// Assertion macros for the pairwise bitset overlap unit
`ifndef MAX_PAIRWISE_BITSET_OVERLAP_UNIT_DEFINES_SVH
`define MAX_PAIRWISE_BITSET_OVERLAP_UNIT_DEFINES_SVH

// same-cycle implication
`define MPBO_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define MPBO_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

### hw/rtl/mpbo_pkg.sv
// Shared types and constants of the pairwise bitset overlap unit
`default_nettype none
package mpbo_pkg;

    localparam int DAY_W    = 5;
    localparam int IDX_W    = 6;
    localparam int CNT_W    = 6;
    localparam int MASK_MAX = 32;

    typedef struct packed {
        logic set_done;
        logic worker_done;
    } t_cmd_flags;

    localparam int FLAGS_W = $bits(t_cmd_flags);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_PAIRS,
        ST_ANSWER
    } t_back_state;

    function automatic logic [CNT_W-1:0] popcount32(input logic [MASK_MAX-1:0] v);
        logic [1:0] l1 [16];
        logic [2:0] l2 [8];
        logic [3:0] l3 [4];
        logic [4:0] l4 [2];
        for (int i = 0; i < 16; i++) begin
            l1[i] = {1'b0, v[2*i]} + {1'b0, v[2*i+1]};
        end
        for (int i = 0; i < 8; i++) begin
            l2[i] = {1'b0, l1[2*i]} + {1'b0, l1[2*i+1]};
        end
        for (int i = 0; i < 4; i++) begin
            l3[i] = {1'b0, l2[2*i]} + {1'b0, l2[2*i+1]};
        end
        for (int i = 0; i < 2; i++) begin
            l4[i] = {1'b0, l3[2*i]} + {1'b0, l3[2*i+1]};
        end
        return {1'b0, l4[0]} + {1'b0, l4[1]};
    endfunction

endpackage
`default_nettype wire

### hw/rtl/max_pairwise_bitset_overlap_unit.sv
// Top level of the pairwise bitset overlap unit.
// Day beats are taken one per cycle while the command queue is not full and ORed into the
// current worker's mask; a beat with tlast (worker end) or tuser[1] (set end) queues a
// command for the back end. A worker completed as number n (from 0) yields n pair beats,
// one per cycle while the output is taken, read through the single read port of the mask
// store. A set end adds one answer beat. Workers beyond MAX_WORKERS are dropped and
// flagged in tuser[1].
`default_nettype none
module max_pairwise_bitset_overlap_unit #(
    parameter int DAYS        = 32,
    parameter int MAX_WORKERS = 64
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_s_axis_tvalid,
    output logic             o_s_axis_tready,
    input  wire logic [7:0]  i_s_axis_tdata,  // [4:0] day, [7:5] zero
    input  wire logic [1:0]  i_s_axis_tuser,  // [0] has_day, [1] set_done
    input  wire logic        i_s_axis_tlast,  // worker_done
    output logic             o_m_axis_tvalid,
    input  wire logic        i_m_axis_tready,
    output logic [23:0]      o_m_axis_tdata,  // [5:0] first_worker, [11:6] second_worker,
                                              // [17:12] common_days, [23:18] best_so_far
    output logic [1:0]       o_m_axis_tuser,  // [0] is_answer, [1] overflow
    output logic             o_m_axis_tlast   // last
);
    import mpbo_pkg::*;

    localparam int MASK_W = (DAYS > MASK_MAX) ? MASK_MAX : DAYS;
    localparam int CMD_W  = MASK_W + FLAGS_W;

    logic              push;
    logic [MASK_W-1:0] push_mask;
    t_cmd_flags        push_flags;
    logic              full;
    logic              empty;
    logic              pop;
    logic [CMD_W-1:0]  q_data;
    t_cmd_flags        q_flags;
    logic [IDX_W-1:0]  first_w;
    logic [IDX_W-1:0]  second_w;
    logic [CNT_W-1:0]  common;
    logic [CNT_W-1:0]  best;

    mpbo_front #(
        .MASK_W(MASK_W)
    ) u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_s_axis_tvalid),
        .o_ready       (o_s_axis_tready),
        .i_day         (i_s_axis_tdata[DAY_W-1:0]),
        .i_has_day     (i_s_axis_tuser[0]),
        .i_worker_done (i_s_axis_tlast),
        .i_set_done    (i_s_axis_tuser[1]),
        .i_full        (full),
        .o_push        (push),
        .o_mask        (push_mask),
        .o_flags       (push_flags)
    );

    mpbo_fifo #(
        .W(CMD_W)
    ) u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  ({push_flags, push_mask}),
        .i_pop   (pop),
        .o_data  (q_data),
        .o_empty (empty),
        .o_full  (full)
    );

    assign q_flags = q_data[CMD_W-1:MASK_W];

    mpbo_back #(
        .MASK_W      (MASK_W),
        .MAX_WORKERS (MAX_WORKERS)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_empty     (empty),
        .i_mask      (q_data[MASK_W-1:0]),
        .i_flags     (q_flags),
        .o_pop       (pop),
        .o_valid     (o_m_axis_tvalid),
        .i_ready     (i_m_axis_tready),
        .o_first     (first_w),
        .o_second    (second_w),
        .o_common    (common),
        .o_best      (best),
        .o_is_answer (o_m_axis_tuser[0]),
        .o_overflow  (o_m_axis_tuser[1]),
        .o_last      (o_m_axis_tlast)
    );

    assign o_m_axis_tdata = {best, common, second_w, first_w};

endmodule
`default_nettype wire

### hw/rtl/mpbo_front.sv
// Front end: accepts day beats, gathers the worker mask, issues commands
`default_nettype none
module mpbo_front #(
    parameter int MASK_W = 32
) (
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    input  wire logic                      i_valid,
    output logic                           o_ready,
    input  wire logic [mpbo_pkg::DAY_W-1:0] i_day,
    input  wire logic                      i_has_day,
    input  wire logic                      i_worker_done,
    input  wire logic                      i_set_done,
    input  wire logic                      i_full,
    output logic                           o_push,
    output logic [MASK_W-1:0]              o_mask,
    output mpbo_pkg::t_cmd_flags           o_flags
);
    import mpbo_pkg::*;

    logic [MASK_W-1:0] r_mask;
    logic [MASK_W-1:0] n_mask;
    logic [MASK_W-1:0] day_hit;
    logic              accept;

    always_comb begin
        for (int i = 0; i < MASK_W; i++) begin
            day_hit[i] = i_has_day && (i_day == DAY_W'(i));
        end
    end

    assign o_ready             = !i_full;
    assign accept              = i_valid && !i_full;
    assign o_mask              = r_mask | day_hit;
    assign o_flags.worker_done = i_worker_done;
    assign o_flags.set_done    = i_set_done;
    assign o_push              = accept && (i_worker_done || i_set_done);

    always_comb begin
        n_mask = r_mask;
        if (accept) begin
            n_mask = o_push ? '0 : o_mask;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mask <= '0;
        end else begin
            r_mask <= n_mask;
        end
    end

endmodule
`default_nettype wire

### hw/rtl/mpbo_fifo.sv
// Two-entry command queue between front and back
`default_nettype none
module mpbo_fifo #(
    parameter int W = 34
) (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  wire logic         i_push,
    input  wire logic [W-1:0] i_data,
    input  wire logic         i_pop,
    output logic [W-1:0]      o_data,
    output logic              o_empty,
    output logic              o_full
);
    logic [W-1:0] r_mem [2];
    logic         r_wp;
    logic         r_rp;
    logic [1:0]   r_cnt;
    logic         do_push;
    logic         do_pop;

    assign o_empty = (r_cnt == 2'd0);
    assign o_full  = (r_cnt == 2'd2);
    assign o_data  = r_mem[r_rp];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wp] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (do_push) begin
                r_wp <= !r_wp;
            end
            if (do_pop) begin
                r_rp <= !r_rp;
            end
            r_cnt <= r_cnt + {1'b0, do_push} - {1'b0, do_pop};
        end
    end

endmodule
`default_nettype wire

### hw/rtl/mpbo_back.sv
// Back end: mask store, pairwise AND/popcount walk, running max, result register
`default_nettype none
module mpbo_back #(
    parameter int MASK_W      = 32,
    parameter int MAX_WORKERS = 64
) (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       i_empty,
    input  wire logic [MASK_W-1:0]          i_mask,
    input  wire mpbo_pkg::t_cmd_flags       i_flags,
    output logic                            o_pop,
    output logic                            o_valid,
    input  wire logic                       i_ready,
    output logic [mpbo_pkg::IDX_W-1:0]      o_first,
    output logic [mpbo_pkg::IDX_W-1:0]      o_second,
    output logic [mpbo_pkg::CNT_W-1:0]      o_common,
    output logic [mpbo_pkg::CNT_W-1:0]      o_best,
    output logic                            o_is_answer,
    output logic                            o_overflow,
    output logic                            o_last
);
    import mpbo_pkg::*;

    localparam int AW = (MAX_WORKERS > 1) ? $clog2(MAX_WORKERS) : 1;
    localparam int CW = $clog2(MAX_WORKERS + 1);

    logic [MASK_W-1:0] r_store [MAX_WORKERS];

    t_back_state       r_state, n_state;
    logic [CW-1:0]     r_count, n_count;
    logic [CW-1:0]     r_w, n_w;
    logic [CW-1:0]     r_j, n_j;
    logic [CW-1:0]     r_rd_idx;
    logic              r_rd_valid, n_rd_valid;
    logic [MASK_W-1:0] r_rd_data;
    logic [MASK_W-1:0] r_cur, n_cur;
    logic              r_set, n_set;
    logic [CNT_W-1:0]  r_best, n_best;
    logic              r_dropped, n_dropped;

    logic              r_o_valid, n_o_valid;
    logic [IDX_W-1:0]  r_o_first, n_o_first;
    logic [IDX_W-1:0]  r_o_second, n_o_second;
    logic [CNT_W-1:0]  r_o_common, n_o_common;
    logic [CNT_W-1:0]  r_o_best, n_o_best;
    logic              r_o_answer, n_o_answer;
    logic              r_o_ovf, n_o_ovf;
    logic              r_o_last, n_o_last;

    logic              wr_en;
    logic              rd_en;
    logic              out_free;
    logic              more;
    logic [CNT_W-1:0]  common;
    logic [CNT_W-1:0]  best_upd;

    assign out_free = !r_o_valid || i_ready;
    assign more     = (r_j < r_w);
    assign common   = popcount32(MASK_MAX'(r_rd_data & r_cur));
    assign best_upd = (common > r_best) ? common : r_best;

    always_comb begin
        n_state    = r_state;
        n_count    = r_count;
        n_w        = r_w;
        n_j        = r_j;
        n_rd_valid = r_rd_valid;
        n_cur      = r_cur;
        n_set      = r_set;
        n_best     = r_best;
        n_dropped  = r_dropped;
        n_o_valid  = r_o_valid && !i_ready;
        n_o_first  = r_o_first;
        n_o_second = r_o_second;
        n_o_common = r_o_common;
        n_o_best   = r_o_best;
        n_o_answer = r_o_answer;
        n_o_ovf    = r_o_ovf;
        n_o_last   = r_o_last;
        o_pop      = 1'b0;
        wr_en      = 1'b0;
        rd_en      = 1'b0;
        case (r_state)
            ST_IDLE: begin
                if (!i_empty) begin
                    o_pop = 1'b1;
                    n_set = i_flags.set_done;
                    if (i_flags.worker_done) begin
                        if (r_count < CW'(MAX_WORKERS)) begin
                            wr_en      = 1'b1;
                            n_cur      = i_mask;
                            n_w        = r_count;
                            n_count    = r_count + CW'(1);
                            n_j        = '0;
                            n_rd_valid = 1'b0;
                            n_state    = ST_PAIRS;
                        end else begin
                            n_dropped = 1'b1;
                            n_state   = i_flags.set_done ? ST_ANSWER : ST_IDLE;
                        end
                    end else begin
                        n_state = ST_ANSWER;
                    end
                end
            end
            ST_PAIRS: begin
                if (r_rd_valid && out_free) begin
                    n_best     = best_upd;
                    n_o_valid  = 1'b1;
                    n_o_first  = IDX_W'(r_rd_idx);
                    n_o_second = IDX_W'(r_w);
                    n_o_common = common;
                    n_o_best   = best_upd;
                    n_o_answer = 1'b0;
                    n_o_ovf    = r_dropped;
                    n_o_last   = ((r_rd_idx + CW'(1)) == r_w) && !r_set;
                end
                if ((!r_rd_valid || out_free) && more) begin
                    rd_en      = 1'b1;
                    n_j        = r_j + CW'(1);
                    n_rd_valid = 1'b1;
                end else if (out_free) begin
                    n_rd_valid = 1'b0;
                end
                if (!more && (!r_rd_valid || out_free)) begin
                    n_state = r_set ? ST_ANSWER : ST_IDLE;
                end
            end
            ST_ANSWER: begin
                if (out_free) begin
                    n_o_valid  = 1'b1;
                    n_o_first  = '0;
                    n_o_second = '0;
                    n_o_common = '0;
                    n_o_best   = r_best;
                    n_o_answer = 1'b1;
                    n_o_ovf    = r_dropped;
                    n_o_last   = 1'b1;
                    n_count    = '0;
                    n_best     = '0;
                    n_dropped  = 1'b0;
                    n_state    = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_store[r_count[AW-1:0]] <= i_mask;
        end
        if (rd_en) begin
            r_rd_data <= r_store[r_j[AW-1:0]];
            r_rd_idx  <= r_j;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= ST_IDLE;
            r_count    <= '0;
            r_w        <= '0;
            r_j        <= '0;
            r_rd_valid <= 1'b0;
            r_set      <= 1'b0;
            r_best     <= '0;
            r_dropped  <= 1'b0;
            r_o_valid  <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_count    <= n_count;
            r_w        <= n_w;
            r_j        <= n_j;
            r_rd_valid <= n_rd_valid;
            r_set      <= n_set;
            r_best     <= n_best;
            r_dropped  <= n_dropped;
            r_o_valid  <= n_o_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cur      <= n_cur;
        r_o_first  <= n_o_first;
        r_o_second <= n_o_second;
        r_o_common <= n_o_common;
        r_o_best   <= n_o_best;
        r_o_answer <= n_o_answer;
        r_o_ovf    <= n_o_ovf;
        r_o_last   <= n_o_last;
    end

    assign o_valid     = r_o_valid;
    assign o_first     = r_o_first;
    assign o_second    = r_o_second;
    assign o_common    = r_o_common;
    assign o_best      = r_o_best;
    assign o_is_answer = r_o_answer;
    assign o_overflow  = r_o_ovf;
    assign o_last      = r_o_last;

endmodule
`default_nettype wire

### hw/rtl/mpbo_checker.sv
// Port-level checks for the pairwise bitset overlap unit, with bind
`default_nettype none
`include "max_pairwise_bitset_overlap_unit_defines.svh"
module mpbo_checker (
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        o_m_axis_tvalid,
    input wire logic        i_m_axis_tready,
    input wire logic [23:0] o_m_axis_tdata,
    input wire logic [1:0]  o_m_axis_tuser,
    input wire logic        o_m_axis_tlast
);
    logic pair_beat;
    logic answer_beat;

    assign pair_beat   = o_m_axis_tvalid && !o_m_axis_tuser[0];
    assign answer_beat = o_m_axis_tvalid && o_m_axis_tuser[0];

    `MPBO_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, o_m_axis_tvalid && !i_m_axis_tready, o_m_axis_tvalid, "result beat dropped while stalled")
    `MPBO_ASSERT_NOW(a_answer_last, i_clk, i_rst_n, answer_beat, o_m_axis_tlast, "answer beat without tlast")
    `MPBO_ASSERT_NOW(a_answer_zero, i_clk, i_rst_n, answer_beat, o_m_axis_tdata[17:0] == 18'd0, "answer beat carries pair fields")
    `MPBO_ASSERT_NOW(a_pair_order, i_clk, i_rst_n, pair_beat, o_m_axis_tdata[5:0] < o_m_axis_tdata[11:6], "pair beat workers out of order")
    `MPBO_ASSERT_NOW(a_pair_best, i_clk, i_rst_n, pair_beat, o_m_axis_tdata[23:18] >= o_m_axis_tdata[17:12], "running max below pair count")

endmodule

bind max_pairwise_bitset_overlap_unit mpbo_checker u_mpbo_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .o_m_axis_tvalid (o_m_axis_tvalid),
    .i_m_axis_tready (i_m_axis_tready),
    .o_m_axis_tdata  (o_m_axis_tdata),
    .o_m_axis_tuser  (o_m_axis_tuser),
    .o_m_axis_tlast  (o_m_axis_tlast)
);
`default_nettype wire

### tb/overlap_checker.sv
// Checker for the pairwise bitset overlap unit: tracks worker masks and compares result beats
module overlap_checker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    input  logic        i_s_tready,
    input  logic [7:0]  i_s_tdata,   // [4:0] day, [7:5] zero
    input  logic [1:0]  i_s_tuser,   // [0] has_day, [1] set_done
    input  logic        i_s_tlast,   // worker_done
    input  logic        i_m_tvalid,
    input  logic        i_m_tready,
    input  logic [23:0] i_m_tdata,   // [5:0] first, [11:6] second, [17:12] common, [23:18] best
    input  logic [1:0]  i_m_tuser,   // [0] is_answer, [1] overflow
    input  logic        i_m_tlast,   // last
    output int          o_mismatches,
    output int          o_outstanding,
    output int          o_checked
);
    import mpbo_pkg::*;

    localparam int STORE_DEPTH = 64;

    typedef struct {
        logic [IDX_W-1:0] first_worker;
        logic [IDX_W-1:0] second_worker;
        logic [CNT_W-1:0] common_days;
        logic [CNT_W-1:0] best_so_far;
        logic             is_answer;
        logic             overflow;
        logic             last;
    } t_overlap_beat;

    logic [MASK_MAX-1:0] gather_mask;
    logic [MASK_MAX-1:0] mask_store [STORE_DEPTH];
    int                  stored_workers;
    logic [CNT_W-1:0]    best_common;
    logic                dropped;
    t_overlap_beat       expected_overlaps [$];
    int                  mismatch_cnt = 0;
    int                  checked_cnt  = 0;

    task automatic queue_overlap(input int first, input int second, input int common,
                                 input logic answer, input logic is_last);
        t_overlap_beat r;
        r.first_worker  = first[IDX_W-1:0];
        r.second_worker = second[IDX_W-1:0];
        r.common_days   = common[CNT_W-1:0];
        r.best_so_far   = best_common;
        r.is_answer     = answer;
        r.overflow      = dropped;
        r.last          = is_last;
        expected_overlaps.insert(expected_overlaps.size(), r);
    endtask

    task automatic track_day_beat(input logic [DAY_W-1:0] day, input logic has_day,
                                  input logic worker_done, input logic set_done);
        int w;
        int common;
        if (has_day)
            gather_mask[day] = 1'b1;
        if (worker_done) begin
            if (stored_workers < STORE_DEPTH) begin
                w = stored_workers;
                mask_store[w] = gather_mask;
                for (int j = 0; j < w; j++) begin
                    common = $countones(mask_store[j] & gather_mask);
                    if (common > int'(best_common))
                        best_common = common[CNT_W-1:0];
                    queue_overlap(j, w, common, 1'b0, (j == w - 1) && !set_done);
                end
                stored_workers = w + 1;
            end else begin
                dropped = 1'b1;
            end
            gather_mask = '0;
        end
        if (set_done) begin
            queue_overlap(0, 0, 0, 1'b1, 1'b1);
            gather_mask    = '0;
            stored_workers = 0;
            best_common    = '0;
            dropped        = 1'b0;
        end
    endtask

    task automatic check_field(input string name, input int want, input int got);
        if (want != got) begin
            $error("%s mismatch: expected %0d, got %0d", name, want, got);
            mismatch_cnt++;
        end
    endtask

    task automatic check_result_beat();
        t_overlap_beat want;
        if (expected_overlaps.size() == 0) begin
            $error("result beat with nothing expected: tdata %h tuser %b tlast %b",
                   i_m_tdata, i_m_tuser, i_m_tlast);
            mismatch_cnt++;
        end else begin
            want = expected_overlaps.pop_front();
            check_field("first_worker",  int'(want.first_worker),  int'(i_m_tdata[5:0]));
            check_field("second_worker", int'(want.second_worker), int'(i_m_tdata[11:6]));
            check_field("common_days",   int'(want.common_days),   int'(i_m_tdata[17:12]));
            check_field("best_so_far",   int'(want.best_so_far),   int'(i_m_tdata[23:18]));
            check_field("is_answer",     int'(want.is_answer),     int'(i_m_tuser[0]));
            check_field("overflow",      int'(want.overflow),      int'(i_m_tuser[1]));
            check_field("last",          int'(want.last),          int'(i_m_tlast));
            checked_cnt++;
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            gather_mask    = '0;
            stored_workers = 0;
            best_common    = '0;
            dropped        = 1'b0;
            expected_overlaps.delete();
        end else begin
            if (i_s_tvalid && i_s_tready)
                track_day_beat(i_s_tdata[DAY_W-1:0], i_s_tuser[0], i_s_tlast, i_s_tuser[1]);
            if (i_m_tvalid && i_m_tready)
                check_result_beat();
        end
        o_outstanding <= expected_overlaps.size();
        o_mismatches  <= mismatch_cnt;
        o_checked     <= checked_cnt;
    end

endmodule

### tb/testbench.sv
// Testbench top: drives day beats and output stalls into the overlap unit and reports the verdict
module testbench;
    import mpbo_pkg::*;

    localparam int IDLE_LIMIT    = 4000;
    localparam int HOLD_CYCLES   = 400;
    localparam int RANDOM_BEATS  = 500;
    localparam int SETTLE_CYCLES = 200;

    typedef enum int {
        RX_STREAM,
        RX_LIGHT,
        RX_HEAVY
    } t_rx_mode;

    logic        clk      = 1'b0;
    logic        rst_n    = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata  = '0;  // [4:0] day, [7:5] zero
    logic [1:0]  s_tuser  = '0;  // [0] has_day, [1] set_done
    logic        s_tlast  = 1'b0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [23:0] m_tdata;        // [5:0] first, [11:6] second, [17:12] common, [23:18] best
    logic [1:0]  m_tuser;        // [0] is_answer, [1] overflow
    logic        m_tlast;

    int mismatches;
    int outstanding;
    int checked;

    logic     hold_req    = 1'b0;
    logic     hold_seen   = 1'b0;
    int       hold_left   = 0;
    int       phase_left  = 0;
    t_rx_mode rx_mode     = RX_STREAM;
    int       idle_cycles = 0;
    int       burst_left  = 0;
    int       beats_sent  = 0;
    int       sets_sent   = 0;

    always #6 clk = ~clk;

    max_pairwise_bitset_overlap_unit u_top (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_s_axis_tvalid (s_tvalid),
        .o_s_axis_tready (s_tready),
        .i_s_axis_tdata  (s_tdata),
        .i_s_axis_tuser  (s_tuser),
        .i_s_axis_tlast  (s_tlast),
        .o_m_axis_tvalid (m_tvalid),
        .i_m_axis_tready (m_tready),
        .o_m_axis_tdata  (m_tdata),
        .o_m_axis_tuser  (m_tuser),
        .o_m_axis_tlast  (m_tlast)
    );

    overlap_checker u_checker (
        .i_clk         (clk),
        .i_rst_n       (rst_n),
        .i_s_tvalid    (s_tvalid),
        .i_s_tready    (s_tready),
        .i_s_tdata     (s_tdata),
        .i_s_tuser     (s_tuser),
        .i_s_tlast     (s_tlast),
        .i_m_tvalid    (m_tvalid),
        .i_m_tready    (m_tready),
        .i_m_tdata     (m_tdata),
        .i_m_tuser     (m_tuser),
        .i_m_tlast     (m_tlast),
        .o_mismatches  (mismatches),
        .o_outstanding (outstanding),
        .o_checked     (checked)
    );

    // output side: stall phases, plus a long hold-off on request
    always @(posedge clk) begin
        if (hold_req != hold_seen) begin
            hold_seen = hold_req;
            hold_left = HOLD_CYCLES;
        end
        if (hold_left > 0) begin
            hold_left--;
            m_tready <= 1'b0;
        end else begin
            if (phase_left == 0) begin
                rx_mode    = t_rx_mode'($urandom_range(0, 2));
                phase_left = $urandom_range(16, 160);
            end
            phase_left--;
            case (rx_mode)
                RX_STREAM: m_tready <= 1'b1;
                RX_LIGHT:  m_tready <= ($urandom_range(0, 3) != 0);
                default:   m_tready <= ($urandom_range(0, 1) == 0);
            endcase
        end
    end

    always @(posedge clk) begin
        if (!rst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles == IDLE_LIMIT) begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    task automatic send_beat(input logic [DAY_W-1:0] day, input logic has_day,
                             input logic worker_done, input logic set_done);
        int gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 24);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
            if (gap > 0) begin
                s_tvalid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        burst_left--;
        s_tvalid <= 1'b1;
        s_tdata  <= {3'b000, day};
        s_tuser  <= {set_done, has_day};
        s_tlast  <= worker_done;
        @(posedge clk iff s_tready);
        beats_sent++;
        if (set_done)
            sets_sent++;
    endtask

    task automatic wait_for_results();
        s_tvalid <= 1'b0;
        @(posedge clk iff (outstanding == 0));
    endtask

    // ndays day beats, the last one closing the worker; zero days gives an empty mask
    task automatic send_worker(input int ndays, input logic end_set);
        for (int k = 0; k < ndays - 1; k++)
            send_beat(DAY_W'($urandom_range(0, 31)), 1'b1, 1'b0, 1'b0);
        if ($urandom_range(0, 9) == 0)
            send_beat(DAY_W'($urandom_range(0, 31)), 1'b0, 1'b0, 1'b0);
        send_beat(DAY_W'($urandom_range(0, 31)), ndays > 0, 1'b1, end_set);
    endtask

    task automatic send_full_worker(input logic end_set);
        for (int d = 0; d < MASK_MAX; d++)
            send_beat(d[DAY_W-1:0], 1'b1, d == MASK_MAX - 1, end_set && d == MASK_MAX - 1);
    endtask

    task automatic send_random_set();
        int   n_workers;
        logic merge_end;
        n_workers = ($urandom_range(0, 7) == 0) ? $urandom_range(7, 14) : $urandom_range(0, 6);
        merge_end = (n_workers > 0) && ($urandom_range(0, 1) == 1);
        for (int k = 0; k < n_workers; k++)
            send_worker($urandom_range(0, 5), merge_end && k == n_workers - 1);
        if (!merge_end) begin
            if ($urandom_range(0, 3) == 0)
                send_beat(DAY_W'($urandom_range(0, 31)), 1'b1, 1'b0, 1'b0);
            send_beat(DAY_W'($urandom_range(0, 31)), 1'($urandom_range(0, 1)), 1'b0, 1'b1);
        end
    endtask

    initial begin
        int directed_beats;
        int set_idx;

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        // set with no workers
        send_beat(5'd0, 1'b0, 1'b0, 1'b1);
        // edge days, ignored empty beat, empty worker, worker end with set end
        send_beat(5'd31, 1'b1, 1'b0, 1'b0);
        send_beat(5'd0,  1'b1, 1'b0, 1'b0);
        send_beat(5'd16, 1'b1, 1'b1, 1'b0);
        send_beat(5'd31, 1'b0, 1'b0, 1'b0);
        send_beat(5'd0,  1'b1, 1'b0, 1'b0);
        send_beat(5'd31, 1'b1, 1'b1, 1'b0);
        send_beat(5'd5,  1'b0, 1'b1, 1'b0);
        send_beat(5'd16, 1'b1, 1'b1, 1'b1);
        // one worker only, then set end dropping a partial mask
        send_beat(5'd10, 1'b1, 1'b1, 1'b0);
        send_beat(5'd10, 1'b1, 1'b0, 1'b1);
        // disjoint pair
        send_beat(5'd21, 1'b1, 1'b1, 1'b0);
        send_beat(5'd10, 1'b1, 1'b1, 1'b0);
        send_beat(5'd0,  1'b0, 1'b0, 1'b1);
        wait_for_results();
        directed_beats = beats_sent;

        set_idx = 0;
        while (beats_sent - directed_beats < RANDOM_BEATS) begin
            case (set_idx)
                4: begin
                    // more workers than the store holds
                    for (int k = 0; k < 68; k++)
                        send_beat(DAY_W'($urandom_range(0, 31)), $urandom_range(0, 7) != 0,
                                  1'b1, k == 67);
                end
                8: begin
                    send_full_worker(1'b0);
                    send_full_worker(1'b0);
                    send_worker($urandom_range(1, 5), 1'b1);
                end
                12: begin
                    hold_req <= ~hold_req;
                    for (int k = 0; k < 24; k++)
                        send_worker(1, k == 23);
                    wait_for_results();
                end
                default: send_random_set();
            endcase
            if ($urandom_range(0, 4) == 0)
                wait_for_results();
            set_idx++;
        end

        wait_for_results();
        repeat (SETTLE_CYCLES) @(posedge clk);

        $display("Sent %0d day beats in %0d sets: empty and single-worker sets, store overflow,",
                 beats_sent, sets_sent);
        $display("full 32-day overlap and a long output hold-off; %0d result beats checked.",
                 checked);
        if (mismatches == 0 && outstanding == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule
